>>> sv/tacu_pkg.sv
// Shared types and fixed constants for the tar archive entry counter.
package tacu_pkg;

  // Block geometry of a tar image.
  localparam int unsigned BLOCK_BYTES    = 512;
  localparam int unsigned BLOCK_IDX_BITS = $clog2(BLOCK_BYTES);
  localparam logic [BLOCK_IDX_BITS-1:0] BLOCK_LAST_IDX = BLOCK_IDX_BITS'(BLOCK_BYTES - 1);

  // Octal size field of a header block.
  localparam int unsigned SIZE_OFFSET = 124;
  localparam int unsigned SIZE_DIGITS = 11;
  localparam int unsigned SIZE_BITS   = 33;
  localparam logic [BLOCK_IDX_BITS-1:0] SIZE_FIRST_IDX = BLOCK_IDX_BITS'(SIZE_OFFSET);
  localparam logic [BLOCK_IDX_BITS-1:0] SIZE_LAST_IDX  =
    BLOCK_IDX_BITS'(SIZE_OFFSET + SIZE_DIGITS - 1);
  localparam logic [7:0] DIGIT_ZERO  = 8'h30;
  localparam logic [7:0] DIGIT_SEVEN = 8'h37;

  // Data blocks still to skip, minus one.
  localparam int unsigned SKIP_BITS = SIZE_BITS - BLOCK_IDX_BITS;

  // Width of the reported entry count.
  localparam int unsigned OUT_COUNT_BITS = 24;

  // One result word.
  typedef struct packed {
    logic [OUT_COUNT_BITS-1:0] entry_count;
    logic                      end_marker_found;
    logic                      count_saturated;
  } result_t;

endpackage

>>> sv/tacu_walker.sv
// Header walker: per-byte block tracking, size parsing and entry counting.
module tacu_walker import tacu_pkg::*; #(
  parameter int unsigned COUNT_BITS = 24
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] data_byte,
  input  logic       image_last,
  output result_t    result
);

  logic [BLOCK_IDX_BITS-1:0] byte_in_block_r, byte_in_block_nxt;
  logic                      in_data_phase_r, in_data_phase_nxt;
  logic [SKIP_BITS-1:0]      data_blocks_left_r, data_blocks_left_nxt;
  logic [SIZE_BITS-1:0]      size_acc_r, size_acc_nxt;
  logic                      size_stopped_r, size_stopped_nxt;
  logic                      block_zero_r, block_zero_nxt;
  logic                      pending_zero_r, pending_zero_nxt;
  logic                      archive_ended_r, archive_ended_nxt;
  logic [COUNT_BITS-1:0]     entries_r, entries_nxt;

  logic                      in_size_field;
  logic                      block_zero_now;
  logic [SIZE_BITS-1:0]      size_now;
  logic [SIZE_BITS-1:0]      size_less_one;
  logic [COUNT_BITS-1:0]     entries_inc1;
  logic [COUNT_BITS-1:0]     entries_inc2;
  logic [COUNT_BITS-1:0]     final_count;

  // Increment that stops at the all-ones value.
  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  // The size field is read only in a header block, up to the first non-octal byte.
  assign in_size_field = !in_data_phase_r && !size_stopped_r &&
                         (byte_in_block_r >= SIZE_FIRST_IDX) &&
                         (byte_in_block_r <= SIZE_LAST_IDX);

  // Zero flag and size value including the current byte.
  always_comb begin
    block_zero_now = block_zero_r && (data_byte == 8'h00);
    size_now       = size_acc_r;
    if (in_size_field && (data_byte inside {[DIGIT_ZERO:DIGIT_SEVEN]})) begin
      size_now = {size_acc_r[SIZE_BITS-4:0], data_byte[2:0]};
    end
  end

  assign size_less_one = size_now - 1'b1;
  assign entries_inc1  = sat_inc(entries_r);
  assign entries_inc2  = sat_inc(entries_inc1);

  // Next state for one byte, with end-of-block decisions on the block's last byte.
  always_comb begin
    byte_in_block_nxt    = byte_in_block_r;
    in_data_phase_nxt    = in_data_phase_r;
    data_blocks_left_nxt = data_blocks_left_r;
    size_acc_nxt         = size_acc_r;
    size_stopped_nxt     = size_stopped_r;
    block_zero_nxt       = block_zero_r;
    pending_zero_nxt     = pending_zero_r;
    archive_ended_nxt    = archive_ended_r;
    entries_nxt          = entries_r;

    if (!archive_ended_r) begin
      block_zero_nxt = block_zero_now;
      size_acc_nxt   = size_now;
      if (in_size_field && !(data_byte inside {[DIGIT_ZERO:DIGIT_SEVEN]})) begin
        size_stopped_nxt = 1'b1;
      end

      if (byte_in_block_r == BLOCK_LAST_IDX) begin
        if (in_data_phase_r) begin
          if (data_blocks_left_r == '0) begin
            in_data_phase_nxt = 1'b0;
          end else begin
            data_blocks_left_nxt = data_blocks_left_r - 1'b1;
          end
        end else if (pending_zero_r) begin
          if (block_zero_now) begin
            archive_ended_nxt = 1'b1;
          end else begin
            // The held zero block and this header both count.
            pending_zero_nxt = 1'b0;
            entries_nxt      = entries_inc2;
            if (size_now != '0) begin
              in_data_phase_nxt    = 1'b1;
              data_blocks_left_nxt = size_less_one[SIZE_BITS-1:BLOCK_IDX_BITS];
            end
          end
        end else if (block_zero_now) begin
          pending_zero_nxt = 1'b1;
        end else begin
          entries_nxt = entries_inc1;
          if (size_now != '0) begin
            in_data_phase_nxt    = 1'b1;
            data_blocks_left_nxt = size_less_one[SIZE_BITS-1:BLOCK_IDX_BITS];
          end
        end
        byte_in_block_nxt = '0;
        block_zero_nxt    = 1'b1;
        size_acc_nxt      = '0;
        size_stopped_nxt  = 1'b0;
      end else begin
        byte_in_block_nxt = byte_in_block_r + 1'b1;
      end
    end
  end

  // A pending zero block still counts when the image ends.
  assign final_count = (pending_zero_nxt && !archive_ended_nxt) ? sat_inc(entries_nxt)
                                                                 : entries_nxt;

  always_comb begin
    result.entry_count      = OUT_COUNT_BITS'(final_count);
    result.end_marker_found = archive_ended_nxt;
    result.count_saturated  = &final_count;
  end

  // Walker state; the last byte of an image returns it to the reset values.
  always_ff @(posedge clk) begin
    if (!rst_n || (step && image_last)) begin
      byte_in_block_r    <= '0;
      in_data_phase_r    <= 1'b0;
      data_blocks_left_r <= '0;
      size_acc_r         <= '0;
      size_stopped_r     <= 1'b0;
      block_zero_r       <= 1'b1;
      pending_zero_r     <= 1'b0;
      archive_ended_r    <= 1'b0;
      entries_r          <= '0;
    end else if (step) begin
      byte_in_block_r    <= byte_in_block_nxt;
      in_data_phase_r    <= in_data_phase_nxt;
      data_blocks_left_r <= data_blocks_left_nxt;
      size_acc_r         <= size_acc_nxt;
      size_stopped_r     <= size_stopped_nxt;
      block_zero_r       <= block_zero_nxt;
      pending_zero_r     <= pending_zero_nxt;
      archive_ended_r    <= archive_ended_nxt;
      entries_r          <= entries_nxt;
    end
  end

endmodule

>>> sv/tar_archive_entry_counter_unit.sv
// Top level of the tar archive entry counter: input register, walker and result register.
//
//   Channel | Ports                                                   | Word
//   --------+---------------------------------------------------------+---------------------------
//   in      | in_valid, in_stall, in_data_byte, in_image_last         | one image byte
//   out     | out_valid, out_stall, out_entry_count,                  | one result per image,
//           | out_end_marker_found, out_count_saturated               | after its last byte
//
// One byte word is taken every cycle while in_stall is low and waits in the input register;
// when it moves on, the walker steps and, on an image's last byte, the result register takes
// the word, so a result is offered from the result register once that byte leaves the input register.
// Short next-state logic in the walker sets the rate of one byte per cycle while nothing stalls.
// Reset is synchronous and clears the valid flags and all walker state.
// A result word held by out_stall keeps a byte in the input register from moving on, which raises in_stall.
module tar_archive_entry_counter_unit import tacu_pkg::*; #(
  parameter int unsigned COUNT_BITS = 24
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [7:0]                in_data_byte,
  input  logic                      in_image_last,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [OUT_COUNT_BITS-1:0] out_entry_count,
  output logic                      out_end_marker_found,
  output logic                      out_count_saturated
);

  logic       in_valid_r;
  logic [7:0] data_byte_r;
  logic       image_last_r;
  logic       out_valid_r;
  result_t    result_r;
  result_t    result;
  logic       advance;

  // A held byte moves on when the result register is free or draining.
  assign advance  = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      data_byte_r  <= in_data_byte;
      image_last_r <= in_image_last;
    end
  end

  tacu_walker #(
    .COUNT_BITS (COUNT_BITS)
  ) u_walker (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (advance),
    .data_byte  (data_byte_r),
    .image_last (image_last_r),
    .result     (result)
  );

  // Result register; only the last byte of an image produces a word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= image_last_r;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && image_last_r) begin
      result_r <= result;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_entry_count      = result_r.entry_count;
  assign out_end_marker_found = result_r.end_marker_found;
  assign out_count_saturated  = result_r.count_saturated;

endmodule
